### hdl/shuffled_lehmer_random_generator_top_defines.svh
// Assertion macros for the shuffled Lehmer generator.
// No dependencies; the using module provides clk_i and rst_ni.
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SLRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SLRG_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

### hdl/slrg_pkg.sv
// Types, constants and the modular fold of the shuffled Lehmer generator.
// No dependencies.
package slrg_pkg;

  localparam int unsigned GEN_W  = 32;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned MUL_W  = 15;
  localparam int unsigned PROD_W = GEN_W + MUL_W;

  localparam logic [MUL_W-1:0] LEHMER_MUL   = 15'd16807;
  localparam logic [VAL_W-1:0] LEHMER_MOD   = 31'h7FFF_FFFF;
  localparam int unsigned      WARMUP_EXTRA = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RS_MUL,
    S_RS_FOLD,
    S_RS_SLOT,
    S_D_RD,
    S_D_FOLD
  } slrg_state_e;

  // Reduce x * 16807 modulo 2^31-1: since 2^31 = 1 (mod M), add high part to low part.
  function automatic logic [VAL_W-1:0] lehmer_fold(input logic [PROD_W-1:0] p);
    logic [VAL_W:0] sum;
    sum = {1'b0, p[VAL_W-1:0]} + (VAL_W+1)'(p[PROD_W-1:VAL_W]);
    if (sum >= {1'b0, LEHMER_MOD}) begin
      sum = sum - {1'b0, LEHMER_MOD};
    end
    return sum[VAL_W-1:0];
  endfunction

endpackage

### hdl/shuffled_lehmer_random_generator_top.sv
// Shuffled minimal-standard Lehmer generator with a Bays-Durham shuffle memory.
// Depends on slrg_pkg and shuffled_lehmer_random_generator_top_defines.svh.
// Draw: an accepted request waits in S_D_FOLD for a free output, then its item is registered;
// no new request is taken before that. A reseed first walks TABLE_DEPTH+8 S_RS_MUL/S_RS_FOLD steps.
// Reset: generator value and shuffle output clear to zero, so the first draw reseeds;
// the shuffle memory is not cleared and is filled by that reseed.
`include "shuffled_lehmer_random_generator_top_defines.svh"

module shuffled_lehmer_random_generator_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value (signed)
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [30:0] random_value, [61:31] generator_out, [63:62] 0
);

  localparam int unsigned GEN_W  = slrg_pkg::GEN_W;
  localparam int unsigned VAL_W  = slrg_pkg::VAL_W;
  localparam int unsigned PROD_W = slrg_pkg::PROD_W;
  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA + 1);

  // Slot = shuffle output / SLOT_DIV, done as a multiply by a rounded-up reciprocal.
  localparam logic [31:0] SLOT_DIV = 32'(1 + (32'h7FFF_FFFE / TABLE_DEPTH));
  localparam int unsigned SLOT_L   = $clog2(SLOT_DIV);
  localparam int unsigned SLOT_SH  = VAL_W + SLOT_L;
  localparam logic [63:0] SLOT_RECIP_FULL =
    ((64'd1 << SLOT_SH) + 64'(SLOT_DIV) - 64'd1) / 64'(SLOT_DIV);
  localparam logic [31:0] SLOT_RECIP = SLOT_RECIP_FULL[31:0];

  slrg_pkg::slrg_state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [GEN_W-1:0]  gen_q, gen_d;
  logic [VAL_W-1:0]  shuf_q, shuf_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  rd_q;
  logic [VAL_W-1:0]  out_rand_q;
  logic [VAL_W-1:0]  out_gen_q;

  logic [VAL_W-1:0]  slot_mem [TABLE_DEPTH];

  logic              accept;
  logic [GEN_W-1:0]  gen_in;
  logic [GEN_W-1:0]  gen_neg;
  logic              need_reseed;
  logic [GEN_W-1:0]  mul_src;
  logic              prod_en;
  logic [VAL_W-1:0]  fold_val;
  logic              draw_fire;
  logic              mem_re;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]  slot_src;
  logic [62:0]       slot_prod;
  logic [62:0]       slot_quot;
  logic [IDX_W-1:0]  slot_next;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign gen_in      = s_axis_tuser ? s_axis_tdata : gen_q;
  assign gen_neg     = ~gen_in + 32'd1;
  assign need_reseed = gen_in[GEN_W-1] || (gen_in == '0) || (shuf_q == '0);
  assign fold_val    = slrg_pkg::lehmer_fold(prod_q);
  assign draw_fire   = (state_q == slrg_pkg::S_D_FOLD) && (!out_valid_q || m_axis_tready);

  assign slot_src  = (state_q == slrg_pkg::S_RS_SLOT) ? gen_q[VAL_W-1:0] : rd_q;
  assign slot_prod = {32'd0, slot_src} * {31'd0, SLOT_RECIP};
  assign slot_quot = slot_prod >> SLOT_SH;
  assign slot_next = (slot_quot >= 63'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                     : slot_quot[IDX_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slrg_pkg::S_IDLE: begin
        if (accept) begin
          state_d = need_reseed ? slrg_pkg::S_RS_MUL : slrg_pkg::S_D_FOLD;
        end
      end
      slrg_pkg::S_RS_MUL:  state_d = slrg_pkg::S_RS_FOLD;
      slrg_pkg::S_RS_FOLD: begin
        state_d = (cnt_q == '0) ? slrg_pkg::S_RS_SLOT : slrg_pkg::S_RS_MUL;
      end
      slrg_pkg::S_RS_SLOT: state_d = slrg_pkg::S_D_RD;
      slrg_pkg::S_D_RD:    state_d = slrg_pkg::S_D_FOLD;
      slrg_pkg::S_D_FOLD: begin
        if (draw_fire) begin
          state_d = slrg_pkg::S_IDLE;
        end
      end
      default: state_d = slrg_pkg::S_IDLE;
    endcase
  end

  // Datapath control and next register values
  always_comb begin
    s_axis_tready = 1'b0;
    mul_src       = gen_q;
    prod_en       = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = slot_q;
    cnt_d         = cnt_q;
    gen_d         = gen_q;
    shuf_d        = shuf_q;
    slot_d        = slot_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    unique case (state_q)
      slrg_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        mul_src       = gen_in;
        if (accept) begin
          cnt_d = CNT_W'(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA);
          if (need_reseed) begin
            gen_d = gen_in[GEN_W-1] ? gen_neg : 32'd1;
          end else begin
            gen_d   = gen_in;
            prod_en = 1'b1;
            mem_re  = 1'b1;
          end
        end
      end
      slrg_pkg::S_RS_MUL: begin
        prod_en = 1'b1;
      end
      slrg_pkg::S_RS_FOLD: begin
        gen_d     = {1'b0, fold_val};
        mem_waddr = cnt_q[IDX_W-1:0];
        // only the last TABLE_DEPTH steps fill the memory, top slot first
        mem_we    = (cnt_q < CNT_W'(TABLE_DEPTH));
        if (cnt_q == '0) begin
          shuf_d = fold_val;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      slrg_pkg::S_RS_SLOT: begin
        slot_d = slot_next;
      end
      slrg_pkg::S_D_RD: begin
        prod_en = 1'b1;
        mem_re  = 1'b1;
      end
      slrg_pkg::S_D_FOLD: begin
        if (draw_fire) begin
          mem_we      = 1'b1;
          gen_d       = {1'b0, fold_val};
          shuf_d      = rd_q;
          slot_d      = slot_next;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slrg_pkg::S_IDLE;
      cnt_q       <= '0;
      gen_q       <= '0;
      shuf_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      shuf_q      <= shuf_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      prod_q <= mul_src * PROD_W'(slrg_pkg::LEHMER_MUL);
    end
    if (draw_fire) begin
      out_rand_q <= rd_q;
      out_gen_q  <= fold_val;
    end
  end

  // Shuffle memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= fold_val;
    end
    if (mem_re) begin
      rd_q <= slot_mem[slot_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_gen_q, out_rand_q};

  `SLRG_ASSERT(a_reseed_starts, (accept && need_reseed) |=> (state_q == slrg_pkg::S_RS_MUL), "reseed not started")
  `SLRG_ASSERT(a_gen_in_range, draw_fire |=> (gen_q < {1'b0, slrg_pkg::LEHMER_MOD}), "generator value out of range")
  `SLRG_ASSERT_NEVER(a_write_outside_fold, mem_we && (state_q != slrg_pkg::S_RS_FOLD) && (state_q != slrg_pkg::S_D_FOLD), "memory write outside fold")
  `SLRG_ASSERT(a_out_from_draw, $rose(out_valid_q) |-> ($past(state_q) == slrg_pkg::S_D_FOLD), "item not from a draw")

endmodule
